// ===== hdl/rpg_pkg.sv =====
// Shared constants and types of the loop region phase generator.
package rpg_pkg;

  localparam int CUE_REGS      = 4;
  localparam int MAX_CUES      = 4;
  localparam int CUE_LIMIT     = (MAX_CUES < CUE_REGS) ? MAX_CUES : CUE_REGS;
  localparam int CUE_IDX_W     = $clog2(CUE_REGS);
  localparam int CUE_CNT_W     = 3;
  localparam int REG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int RATE_W        = 24;
  localparam int POINT_W       = 17;
  localparam int POS_W         = 33;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CUE_CNT_W-1:0] CUE_LIMIT_V = CUE_CNT_W'(CUE_LIMIT);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BUFFER_SIZE,
    REG_CUE_COUNT,
    REG_CUE_ZERO,
    REG_CUE_ONE,
    REG_CUE_TWO,
    REG_CUE_THREE,
    REG_START_SAMPLE,
    REG_START_REVERSE
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]                     buffer_size;
    logic [CUE_CNT_W-1:0]            cue_count;
    logic [CUE_REGS-1:0][15:0]       cue;
    logic [15:0]                     start_sample;
    logic                            start_reverse;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic                 mul_s;
    logic                 mul_e;
    logic                 order;
    logic                 step;
    logic                 fix;
    logic                 prev;
    logic                 scan;
    logic                 emit;
    logic                 emit_cue;
    logic                 emit_last;
    logic                 commit;
    logic [CUE_IDX_W-1:0] cue_idx;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } status_t;

endpackage

// ===== hdl/rpg_ifs.sv =====
// Channel interfaces: tick input, result output and register write port.
interface rpg_tick_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [rpg_pkg::RATE_W-1:0]          rate;
  logic        [rpg_pkg::POINT_W-1:0]         loop_start;
  logic        [rpg_pkg::POINT_W-1:0]         loop_end;
  logic                                       loop_on;
  logic                                       from_edge;
  logic                                       play_to_end;

  modport source (output valid, rate, loop_start, loop_end, loop_on, from_edge, play_to_end,
                  input ready);
  modport sink   (input valid, rate, loop_start, loop_end, loop_on, from_edge, play_to_end,
                  output ready);
endinterface

interface rpg_result_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [rpg_pkg::POS_W-1:0]           position;
  logic                                       finished;
  logic                                       is_cue_event;
  logic        [rpg_pkg::CUE_IDX_W-1:0]       cue_index;
  logic                                       last_of_run;

  modport source (output valid, position, finished, is_cue_event, cue_index, last_of_run,
                  input ready);
  modport sink   (input valid, position, finished, is_cue_event, cue_index, last_of_run,
                  output ready);
endinterface

interface rpg_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [rpg_pkg::REG_IDX_W-1:0]              index;
  logic [rpg_pkg::CFG_DATA_W-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rpg_cfg.sv =====
// Configuration register file with start position reload strobe.
module rpg_cfg (
  input  logic            clk,
  input  logic            rst,
  rpg_cfg_if.sink         cfg,
  output rpg_pkg::cfg_t   regs,
  output logic            reload
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.buffer_size   <= 16'hFFFF;
      regs.cue_count     <= '0;
      regs.cue           <= '0;
      regs.start_sample  <= '0;
      regs.start_reverse <= 1'b0;
      reload             <= 1'b0;
    end else begin
      reload <= cfg.valid && (cfg.index == rpg_pkg::REG_START_SAMPLE ||
                              cfg.index == rpg_pkg::REG_START_REVERSE);
      if (cfg.valid) begin
        unique case (rpg_pkg::reg_idx_t'(cfg.index))
          rpg_pkg::REG_BUFFER_SIZE:   regs.buffer_size <= cfg.data;
          rpg_pkg::REG_CUE_COUNT:     regs.cue_count <= cfg.data[rpg_pkg::CUE_CNT_W-1:0];
          rpg_pkg::REG_CUE_ZERO:      regs.cue[0] <= cfg.data;
          rpg_pkg::REG_CUE_ONE:       regs.cue[1] <= cfg.data;
          rpg_pkg::REG_CUE_TWO:       regs.cue[2] <= cfg.data;
          rpg_pkg::REG_CUE_THREE:     regs.cue[3] <= cfg.data;
          rpg_pkg::REG_START_SAMPLE:  regs.start_sample <= cfg.data;
          rpg_pkg::REG_START_REVERSE: regs.start_reverse <= cfg.data[0];
        endcase
      end
    end
  end

endmodule

// ===== hdl/rpg_ctrl.sv =====
// Sequencer: steps the datapath through one tick and issues its results.
module rpg_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick_valid,
  output logic                             tick_ready,
  output logic                             res_valid,
  input  logic                             res_ready,
  input  logic [rpg_pkg::CUE_CNT_W-1:0]    cue_count,
  input  rpg_pkg::status_t                 status,
  output rpg_pkg::cmd_t                    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_S,
    S_MUL_E,
    S_ORDER,
    S_STEP,
    S_FIX,
    S_PREV,
    S_SCAN,
    S_EMIT_POS,
    S_EMIT_CUE
  } state_t;

  state_t                               state;
  logic [rpg_pkg::CUE_IDX_W-1:0]        idx;
  logic [rpg_pkg::CUE_REGS-1:0]         hits;
  logic [rpg_pkg::CUE_IDX_W-1:0]        sel;
  logic [rpg_pkg::CUE_REGS-1:0]         rest;
  logic [rpg_pkg::CUE_CNT_W-1:0]        cue_lim;
  logic                                 out_free;

  assign cue_lim    = (cue_count > rpg_pkg::CUE_LIMIT_V) ? rpg_pkg::CUE_LIMIT_V : cue_count;
  assign out_free   = !res_valid || res_ready;
  assign tick_ready = (state == S_IDLE);

  always_comb begin
    sel = '0;
    for (int i = rpg_pkg::CUE_REGS - 1; i >= 0; i--) begin
      if (hits[i]) sel = rpg_pkg::CUE_IDX_W'(i);
    end
    rest      = hits;
    rest[sel] = 1'b0;
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load  = tick_valid;
      S_MUL_S: cmd.mul_s = 1'b1;
      S_MUL_E: cmd.mul_e = 1'b1;
      S_ORDER: cmd.order = 1'b1;
      S_STEP:  cmd.step  = 1'b1;
      S_FIX:   cmd.fix   = 1'b1;
      S_PREV:  cmd.prev  = 1'b1;
      S_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.cue_idx = idx;
      end
      S_EMIT_POS: begin
        cmd.emit      = out_free;
        cmd.emit_last = (hits == '0);
        cmd.commit    = out_free && (hits == '0);
      end
      S_EMIT_CUE: begin
        cmd.emit      = out_free;
        cmd.emit_cue  = 1'b1;
        cmd.cue_idx   = sel;
        cmd.emit_last = (rest == '0);
        cmd.commit    = out_free && (rest == '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      idx       <= '0;
      hits      <= '0;
    end else begin
      if (cmd.emit) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (tick_valid) state <= S_MUL_S;
        S_MUL_S: state <= S_MUL_E;
        S_MUL_E: state <= S_ORDER;
        S_ORDER: state <= S_STEP;
        S_STEP:  state <= S_FIX;
        S_FIX:   state <= S_PREV;
        S_PREV: begin
          hits  <= '0;
          idx   <= '0;
          state <= (cue_lim != '0) ? S_SCAN : S_EMIT_POS;
        end
        S_SCAN: begin
          hits[idx] <= status.hit;
          if (rpg_pkg::CUE_CNT_W'(idx) == cue_lim - 1'b1) begin
            state <= S_EMIT_POS;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT_POS: if (out_free) state <= (hits == '0) ? S_IDLE : S_EMIT_CUE;
        S_EMIT_CUE: begin
          if (out_free) begin
            hits <= rest;
            if (rest == '0) state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/rpg_dp.sv =====
// Datapath: region scaling, position advance, wrap and stop, cue compare, result register.
module rpg_dp #(
  parameter int FRAC_BITS = rpg_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic signed [rpg_pkg::RATE_W-1:0]        rate,
  input  logic        [rpg_pkg::POINT_W-1:0]       loop_start,
  input  logic        [rpg_pkg::POINT_W-1:0]       loop_end,
  input  logic                                     loop_on,
  input  logic                                     from_edge,
  input  logic                                     play_to_end,
  input  rpg_pkg::cfg_t                            regs,
  input  logic                                     reload,
  input  rpg_pkg::cmd_t                            cmd,
  output rpg_pkg::status_t                         status,
  output logic signed [rpg_pkg::POS_W-1:0]         position,
  output logic                                     finished,
  output logic                                     is_cue_event,
  output logic        [rpg_pkg::CUE_IDX_W-1:0]     cue_index,
  output logic                                     last_of_run
);

  localparam int UP_SHIFT = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DN_SHIFT = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int PW       = 33 + UP_SHIFT;
  localparam int WW       = PW + 2;
  localparam int RE_W     = rpg_pkg::RATE_W + 1;
  localparam int PS_W     = rpg_pkg::POS_W;

  localparam logic signed [WW-1:0]   ONE_W     = {{(WW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [PS_W-1:0] ONE_P     = {{(PS_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [WW-1:0]   POS_MIN_W = {{(WW-32){1'b1}}, 32'b0};
  localparam logic signed [WW-1:0]   POS_MAX_W = {{(WW-32){1'b0}}, {32{1'b1}}};

  typedef enum logic [1:0] {
    ADJ_NONE,
    ADJ_DEC,
    ADJ_INC
  } adj_t;

  function automatic logic signed [PS_W-1:0] sat_pos(input logic signed [WW-1:0] v);
    logic signed [PS_W-1:0] r;
    if (v < POS_MIN_W) r = POS_MIN_W[PS_W-1:0];
    else if (v > POS_MAX_W) r = POS_MAX_W[PS_W-1:0];
    else r = v[PS_W-1:0];
    return r;
  endfunction

  // Tick operands
  logic signed [rpg_pkg::RATE_W-1:0]   rate_in;
  logic        [rpg_pkg::POINT_W-1:0]  start_in;
  logic        [rpg_pkg::POINT_W-1:0]  end_in;
  logic                                loop_in;
  logic                                jump_edge;
  logic                                to_end;

  // Working registers
  logic [PW-1:0]                       pt_s;
  logic [PW-1:0]                       pt_e;
  logic [PW-1:0]                       lo;
  logic [PW-1:0]                       hi;
  logic [PW-1:0]                       span;
  logic signed [RE_W-1:0]              rate_eff;
  logic signed [PS_W-1:0]              cur;
  logic signed [PS_W-1:0]              prv;
  adj_t                                adj;

  // Phase state
  logic signed [PS_W-1:0]              phase_now;
  logic signed [PS_W-1:0]              phase_before;
  logic                                was_looping;
  logic                                done_flag;

  // Scaling
  logic [32:0]                         prod;
  logic [PW-1:0]                       prod_w;
  logic [PW-1:0]                       scaled;

  always_comb begin
    prod   = {16'b0, (cmd.mul_e ? end_in : start_in)} * {17'b0, regs.buffer_size};
    prod_w = PW'(prod);
    scaled = (prod_w << UP_SHIFT) >> DN_SHIFT;
  end

  // Region order
  logic                                swap;
  logic signed [RE_W-1:0]              rate_ext;

  assign swap     = pt_s > pt_e;
  assign rate_ext = RE_W'(rate_in);

  // Wrap and stop
  logic signed [WW-1:0] cr, lo_w, hi_w, span_w, buf_w, fix_val, step_sum;
  logic                 rpos, rneg, fix_done;
  adj_t                 fix_adj;

  assign cr       = WW'(cur);
  assign lo_w     = $signed(WW'(lo));
  assign hi_w     = $signed(WW'(hi));
  assign span_w   = $signed(WW'(span));
  assign buf_w    = $signed(WW'(regs.buffer_size)) <<< FRAC_BITS;
  assign rneg     = rate_eff[RE_W-1];
  assign rpos     = !rate_eff[RE_W-1] && (rate_eff != '0);
  assign step_sum = WW'(phase_now) + WW'(rate_eff);

  always_comb begin
    fix_val  = cr;
    fix_done = 1'b0;
    fix_adj  = ADJ_NONE;
    if (loop_in) begin
      if (rpos && cr >= hi_w) begin
        fix_adj = ADJ_DEC;
        if (!was_looping) fix_val = jump_edge ? '0 : lo_w;
        else fix_val = cr - span_w;
      end else if (rneg && cr < lo_w) begin
        fix_adj = ADJ_INC;
        if (!was_looping) fix_val = jump_edge ? buf_w - ONE_W : hi_w;
        else fix_val = cr + span_w;
      end
    end else if (!to_end) begin
      if (rpos && cr >= hi_w) begin
        fix_val  = buf_w;
        fix_done = 1'b1;
      end else if (rneg && cr < lo_w) begin
        fix_val  = -ONE_W;
        fix_done = 1'b1;
      end
    end else begin
      fix_done = (rpos && cr >= buf_w) || (rneg && cr[WW-1]);
    end
  end

  // Cue compare
  logic signed [WW-1:0] cue_w, prv_w;

  assign cue_w = $signed(WW'(regs.cue[cmd.cue_idx])) <<< FRAC_BITS;
  assign prv_w = WW'(prv);

  always_comb begin
    if (!rate_eff[RE_W-1]) status.hit = (prv_w < cue_w) && (cr >= cue_w);
    else status.hit = (prv_w > cue_w) && (cr <= cue_w);
  end

  // Start position reload
  logic signed [WW-1:0]   start_w;
  logic signed [PS_W-1:0] start_sat;
  logic signed [PS_W-1:0] before_ld;

  assign start_w   = $signed(WW'(regs.start_sample)) <<< FRAC_BITS;
  assign start_sat = sat_pos(start_w);
  assign before_ld = regs.start_reverse ? sat_pos(buf_w) : sat_pos(WW'(start_sat) - ONE_W);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_in   <= rate;
      start_in  <= loop_start;
      end_in    <= loop_end;
      loop_in   <= loop_on;
      jump_edge <= from_edge;
      to_end    <= play_to_end;
    end
    if (cmd.mul_s) pt_s <= scaled;
    if (cmd.mul_e) pt_e <= scaled;
    if (cmd.order) begin
      lo       <= swap ? pt_e : pt_s;
      hi       <= swap ? pt_s : pt_e;
      span     <= swap ? pt_s - pt_e : pt_e - pt_s;
      rate_eff <= swap ? -rate_ext : rate_ext;
    end
    if (cmd.step) begin
      cur <= sat_pos(step_sum);
      prv <= phase_before;
    end
    if (cmd.fix) begin
      cur <= sat_pos(fix_val);
      adj <= fix_adj;
    end
    if (cmd.prev) begin
      case (adj)
        ADJ_DEC: prv <= sat_pos(cr - ONE_W);
        ADJ_INC: prv <= sat_pos(cr + ONE_W);
        default: prv <= prv;
      endcase
    end
    if (cmd.emit) begin
      position     <= cur;
      finished     <= done_flag;
      is_cue_event <= cmd.emit_cue;
      cue_index    <= cmd.emit_cue ? cmd.cue_idx : '0;
      last_of_run  <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_now    <= '0;
      phase_before <= -ONE_P;
      was_looping  <= 1'b0;
      done_flag    <= 1'b0;
    end else begin
      if (reload) begin
        phase_now    <= start_sat;
        phase_before <= before_ld;
      end
      if (cmd.fix && fix_done) done_flag <= 1'b1;
      if (cmd.commit) begin
        phase_now    <= cur;
        phase_before <= cur;
        was_looping  <= loop_in;
      end
    end
  end

endmodule

// ===== hdl/loop_region_phase_generator.sv =====
// Loop region phase generator top level: register file, sequencer and datapath.
// Per tick the sequencer steps the shared 17x16 region multiplier for start and end,
// then the order, advance, wrap and previous-position stages, then the cue compare of
// L = min(cue_count, 4) cues, one cue per cycle; it emits the position and one result
// per cue crossed, waiting on result stalls, and takes a new tick only after the last.
// Reset: registers take their defaults, position 0, previous position minus one sample.
module loop_region_phase_generator #(
  parameter int FRAC_BITS = rpg_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rpg_tick_if.sink       tick,
  rpg_result_if.source   result,
  rpg_cfg_if.sink        cfg
);

  rpg_pkg::cfg_t    regs;
  rpg_pkg::cmd_t    cmd;
  rpg_pkg::status_t status;
  logic             reload;

  rpg_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .regs   (regs),
    .reload (reload)
  );

  rpg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .cue_count  (regs.cue_count),
    .status     (status),
    .cmd        (cmd)
  );

  rpg_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .rate         (tick.rate),
    .loop_start   (tick.loop_start),
    .loop_end     (tick.loop_end),
    .loop_on      (tick.loop_on),
    .from_edge    (tick.from_edge),
    .play_to_end  (tick.play_to_end),
    .regs         (regs),
    .reload       (reload),
    .cmd          (cmd),
    .status       (status),
    .position     (result.position),
    .finished     (result.finished),
    .is_cue_event (result.is_cue_event),
    .cue_index    (result.cue_index),
    .last_of_run  (result.last_of_run)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Loop region phase generator testbench: directed and random ticks checked against a predictor.
module testbench;

  typedef struct {
    logic signed [rpg_pkg::RATE_W-1:0] rate;
    logic [rpg_pkg::POINT_W-1:0]       loop_start;
    logic [rpg_pkg::POINT_W-1:0]       loop_end;
    logic                              loop_on;
    logic                              from_edge;
    logic                              play_to_end;
  } tick_t;

  typedef struct {
    logic [rpg_pkg::POS_W-1:0]     position;
    logic                          finished;
    logic                          is_cue_event;
    logic [rpg_pkg::CUE_IDX_W-1:0] cue_index;
    logic                          last_of_run;
  } phase_result_t;

  localparam longint SAMPLE_ONE = 64'sd65536;
  localparam longint POS_LOW    = -64'sd4294967296;
  localparam longint POS_HIGH   = 64'sd4294967295;
  localparam logic signed [rpg_pkg::RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
  localparam logic signed [rpg_pkg::RATE_W-1:0] RATE_MIN = 24'sh800000;

  logic clk;
  logic rst;

  rpg_tick_if   tick_ch ();
  rpg_result_if res_ch ();
  rpg_cfg_if    cfg_ch ();

  loop_region_phase_generator dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  logic [15:0]                   buffer_size_r;
  logic [rpg_pkg::CUE_CNT_W-1:0] cue_count_r;
  logic [15:0]                   cue_r [rpg_pkg::CUE_REGS];
  logic [15:0]                   start_sample_r;
  logic                          start_reverse_r;

  longint phase_now;
  longint phase_before;
  bit     was_looping;
  bit     done_flag;

  tick_t         ticks_to_send [$];
  phase_result_t phase_results_due [$];
  int            error_count;
  int            send_idle_pct;
  int            recv_idle_pct;

  function automatic longint clip_pos(longint v);
    if (v < POS_LOW) return POS_LOW;
    if (v > POS_HIGH) return POS_HIGH;
    return v;
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic void load_start_position();
    phase_now = clip_pos(longint'(start_sample_r) * SAMPLE_ONE);
    if (start_reverse_r) phase_before = clip_pos(longint'(buffer_size_r) * SAMPLE_ONE);
    else phase_before = clip_pos(phase_now - SAMPLE_ONE);
  endfunction

  function automatic void reset_phase_model();
    buffer_size_r = 16'hFFFF;
    cue_count_r = '0;
    foreach (cue_r[i]) cue_r[i] = '0;
    start_sample_r = '0;
    start_reverse_r = 1'b0;
    was_looping = 1'b0;
    done_flag = 1'b0;
    load_start_position();
  endfunction

  function automatic void apply_reg(rpg_pkg::reg_idx_t idx, logic [15:0] value);
    case (idx)
      rpg_pkg::REG_BUFFER_SIZE: buffer_size_r = value;
      rpg_pkg::REG_CUE_COUNT: cue_count_r = value[rpg_pkg::CUE_CNT_W-1:0];
      rpg_pkg::REG_CUE_ZERO: cue_r[0] = value;
      rpg_pkg::REG_CUE_ONE: cue_r[1] = value;
      rpg_pkg::REG_CUE_TWO: cue_r[2] = value;
      rpg_pkg::REG_CUE_THREE: cue_r[3] = value;
      rpg_pkg::REG_START_SAMPLE: begin
        start_sample_r = value;
        load_start_position();
      end
      rpg_pkg::REG_START_REVERSE: begin
        start_reverse_r = value[0];
        load_start_position();
      end
      default: ;
    endcase
  endfunction

  function automatic void advance_phase_model(tick_t t);
    longint step_v, s, e, bufpos, cur, prev, c, tmp;
    bit fwd, hit;
    int lim, i;
    phase_result_t run [$];
    phase_result_t r;
    step_v = longint'(t.rate);
    s = longint'(t.loop_start) * longint'(buffer_size_r);
    e = longint'(t.loop_end) * longint'(buffer_size_r);
    bufpos = longint'(buffer_size_r) * SAMPLE_ONE;
    if (s > e) begin
      tmp = s;
      s = e;
      e = tmp;
      step_v = -step_v;
    end
    cur = clip_pos(phase_now + step_v);
    prev = phase_before;
    if (t.loop_on) begin
      if (step_v > 0 && cur >= e) begin
        cur = was_looping ? cur - (e - s) : (t.from_edge ? 64'sd0 : s);
        cur = clip_pos(cur);
        prev = clip_pos(cur - SAMPLE_ONE);
      end else if (step_v < 0 && cur < s) begin
        cur = was_looping ? cur + (e - s) : (t.from_edge ? bufpos - SAMPLE_ONE : e);
        cur = clip_pos(cur);
        prev = clip_pos(cur + SAMPLE_ONE);
      end
    end else if (!t.play_to_end) begin
      if (step_v > 0 && cur >= e) begin
        cur = clip_pos(bufpos);
        done_flag = 1'b1;
      end else if (step_v < 0 && cur < s) begin
        cur = -SAMPLE_ONE;
        done_flag = 1'b1;
      end
    end else if ((step_v > 0 && cur >= bufpos) || (step_v < 0 && cur < 0)) begin
      done_flag = 1'b1;
    end

    r.position = cur[rpg_pkg::POS_W-1:0];
    r.finished = done_flag;
    r.is_cue_event = 1'b0;
    r.cue_index = '0;
    r.last_of_run = 1'b0;
    run.push_back(r);

    fwd = step_v >= 0;
    lim = (int'(cue_count_r) > rpg_pkg::CUE_LIMIT) ? rpg_pkg::CUE_LIMIT : int'(cue_count_r);
    for (i = 0; i < lim; i++) begin
      c = longint'(cue_r[i]) * SAMPLE_ONE;
      hit = fwd ? (prev < c && cur >= c) : (prev > c && cur <= c);
      if (hit) begin
        r.is_cue_event = 1'b1;
        r.cue_index = i[rpg_pkg::CUE_IDX_W-1:0];
        run.push_back(r);
      end
    end
    run[run.size()-1].last_of_run = 1'b1;
    foreach (run[k]) phase_results_due.push_back(run[k]);

    phase_now = cur;
    phase_before = cur;
    was_looping = t.loop_on;
  endfunction

  function automatic tick_t make_random_tick();
    tick_t t;
    longint span;
    int kind;
    kind = $urandom_range(99);
    if (kind < 80) begin
      span = longint'(buffer_size_r) * SAMPLE_ONE / 3;
      if (span > 64'sd8388607) span = 64'sd8388607;
      if (span < 1) span = 1;
      t.rate = rpg_pkg::RATE_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
      if (kind < 5) t.rate = '0;
      t.loop_start = rpg_pkg::POINT_W'($urandom_range(0, 65536));
      t.loop_end = rpg_pkg::POINT_W'($urandom_range(0, 65536));
      t.loop_on = ($urandom_range(99) < 70);
      t.from_edge = 1'($urandom_range(1));
      t.play_to_end = 1'($urandom_range(1));
    end else begin
      t.rate = rpg_pkg::RATE_W'($urandom());
      t.loop_start = rpg_pkg::POINT_W'($urandom());
      t.loop_end = rpg_pkg::POINT_W'($urandom());
      t.loop_on = 1'($urandom_range(1));
      t.from_edge = 1'($urandom_range(1));
      t.play_to_end = 1'($urandom_range(1));
    end
    return t;
  endfunction

  task automatic add_tick(logic signed [rpg_pkg::RATE_W-1:0] rate,
                          logic [rpg_pkg::POINT_W-1:0] ls, logic [rpg_pkg::POINT_W-1:0] le,
                          logic lp, logic edge_jump, logic to_end);
    tick_t t;
    t.rate = rate;
    t.loop_start = ls;
    t.loop_end = le;
    t.loop_on = lp;
    t.from_edge = edge_jump;
    t.play_to_end = to_end;
    ticks_to_send.push_back(t);
  endtask

  task automatic write_reg(rpg_pkg::reg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, value);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (ticks_to_send.size() != 0 || phase_results_due.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic randomize_config();
    logic [15:0] bsize;
    case ($urandom_range(9))
      0: bsize = 16'd1;
      1: bsize = 16'hFFFF;
      default: bsize = 16'($urandom_range(2, 300));
    endcase
    write_reg(rpg_pkg::REG_BUFFER_SIZE, bsize);
    write_reg(rpg_pkg::REG_CUE_COUNT,
              (16'($urandom()) & 16'hFFF8) | 16'($urandom_range(0, 7)));
    write_reg(rpg_pkg::REG_CUE_ZERO, 16'($urandom_range(0, bsize)));
    write_reg(rpg_pkg::REG_CUE_ONE, 16'($urandom_range(0, bsize)));
    write_reg(rpg_pkg::REG_CUE_TWO, 16'($urandom_range(0, bsize)));
    write_reg(rpg_pkg::REG_CUE_THREE, ($urandom_range(9) == 0) ? 16'($urandom()) :
                                      16'($urandom_range(0, bsize)));
    write_reg(rpg_pkg::REG_START_SAMPLE, 16'($urandom_range(0, bsize)));
    write_reg(rpg_pkg::REG_START_REVERSE, 16'($urandom()));
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin : tick_driver
    bit took;
    if (rst) begin
      tick_ch.valid <= 1'b0;
      tick_ch.rate <= '0;
      tick_ch.loop_start <= '0;
      tick_ch.loop_end <= '0;
      tick_ch.loop_on <= 1'b0;
      tick_ch.from_edge <= 1'b0;
      tick_ch.play_to_end <= 1'b0;
    end else begin
      took = tick_ch.valid && tick_ch.ready;
      if (took) advance_phase_model(ticks_to_send.pop_front());
      if (!tick_ch.valid || took) begin
        if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_ch.valid <= 1'b1;
          tick_ch.rate <= ticks_to_send[0].rate;
          tick_ch.loop_start <= ticks_to_send[0].loop_start;
          tick_ch.loop_end <= ticks_to_send[0].loop_end;
          tick_ch.loop_on <= ticks_to_send[0].loop_on;
          tick_ch.from_edge <= ticks_to_send[0].from_edge;
          tick_ch.play_to_end <= ticks_to_send[0].play_to_end;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    phase_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (phase_results_due.size() == 0) begin
          note_error($sformatf("unexpected result position=%h cue=%b idx=%0d",
                               res_ch.position, res_ch.is_cue_event, res_ch.cue_index));
        end else begin
          want = phase_results_due.pop_front();
          if (res_ch.position !== want.position || res_ch.finished !== want.finished ||
              res_ch.is_cue_event !== want.is_cue_event ||
              res_ch.cue_index !== want.cue_index ||
              res_ch.last_of_run !== want.last_of_run)
            note_error($sformatf({"expected pos=%h fin=%b cue=%b idx=%0d last=%b, ",
                                  "got pos=%h fin=%b cue=%b idx=%0d last=%b"},
                                 want.position, want.finished, want.is_cue_event,
                                 want.cue_index, want.last_of_run, res_ch.position,
                                 res_ch.finished, res_ch.is_cue_event, res_ch.cue_index,
                                 res_ch.last_of_run));
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    error_count = 0;
    send_idle_pct = 8;
    recv_idle_pct = 66;
    reset_phase_model();
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= rpg_pkg::REG_BUFFER_SIZE;
    cfg_ch.data <= '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_tick(RATE_MAX, 0, 65536, 0, 0, 1);
    wait_drained();

    write_reg(rpg_pkg::REG_BUFFER_SIZE, 16'd1000);
    write_reg(rpg_pkg::REG_CUE_COUNT, 16'd4);
    write_reg(rpg_pkg::REG_CUE_ZERO, 16'd0);
    write_reg(rpg_pkg::REG_CUE_ONE, 16'd150);
    write_reg(rpg_pkg::REG_CUE_TWO, 16'd400);
    write_reg(rpg_pkg::REG_CUE_THREE, 16'd999);
    write_reg(rpg_pkg::REG_START_SAMPLE, 16'd100);
    write_reg(rpg_pkg::REG_START_REVERSE, 16'd0);
    add_tick('0, 0, 65536, 0, 0, 0);
    repeat (8) add_tick(RATE_MAX, 0, 65536, 1, 0, 0);
    add_tick(RATE_MAX, 0, 6554, 0, 0, 1);
    add_tick(RATE_MAX, 0, 6554, 1, 1, 0);
    add_tick(24'sd65536, 0, 65536, 0, 0, 1);
    add_tick(RATE_MIN, 52429, 65536, 1, 1, 0);
    repeat (6) add_tick(RATE_MAX, 52429, 13107, 1, 0, 0);
    add_tick(RATE_MAX, 0, 32768, 0, 0, 0);
    add_tick(RATE_MIN, 32768, 65536, 0, 0, 0);
    add_tick(RATE_MIN, 0, 65536, 0, 0, 1);
    add_tick('0, 131071, 131071, 1, 1, 1);
    add_tick(RATE_MAX, 131071, 0, 1, 0, 0);
    wait_drained();

    write_reg(rpg_pkg::REG_BUFFER_SIZE, 16'hFFFF);
    write_reg(rpg_pkg::REG_CUE_COUNT, 16'd7);
    write_reg(rpg_pkg::REG_CUE_ZERO, 16'hFFFF);
    write_reg(rpg_pkg::REG_CUE_THREE, 16'd32768);
    write_reg(rpg_pkg::REG_START_SAMPLE, 16'hFFFF);
    write_reg(rpg_pkg::REG_START_REVERSE, 16'd1);
    repeat (2) add_tick(RATE_MAX, 65536, 65536, 0, 0, 1);
    wait_drained();

    write_reg(rpg_pkg::REG_BUFFER_SIZE, 16'd0);
    write_reg(rpg_pkg::REG_START_REVERSE, 16'd0);
    write_reg(rpg_pkg::REG_START_SAMPLE, 16'd0);
    add_tick(RATE_MAX, 65536, 0, 1, 1, 0);
    add_tick(RATE_MIN, 0, 0, 0, 0, 0);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 66 : 0;
      recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 8 : 0;
      repeat (2) begin
        randomize_config();
        repeat (2) begin
          repeat (6) ticks_to_send.push_back(make_random_tick());
          wait_drained();
        end
      end
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
